### rtl/haf_pkg.sv
// ----------------------------------------------------------------------------
// haf_pkg
// Shared widths, register map, configuration, divider and state types for the
// harmonic alias folder.
// ----------------------------------------------------------------------------
package haf_pkg;

	localparam int MAX_PARTIALS = 64;
	localparam int RESULT_LIMIT = 64;

	localparam int FUND_W   = 24;
	localparam int SRATE_W  = 24;
	localparam int NPART_W  = 7;
	localparam int RATE_W   = 16;
	localparam int FREQ_W   = 30;
	localparam int NY_W     = 31;
	localparam int SRATE_SH = 7;

	localparam int DIV_W     = 31;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_FUND  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRATE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NPART = 2'd2;

	localparam logic [FUND_W-1:0]  FUND_RST  = 24'd112640;
	localparam logic [SRATE_W-1:0] SRATE_RST = 24'd48000;
	localparam logic [NPART_W-1:0] NPART_RST = 7'd16;

	typedef struct packed {
		logic [FUND_W-1:0]  fund;
		logic [SRATE_W-1:0] srate;
		logic [NPART_W-1:0] nparts;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_NY_WAIT = 5'b00010,
		ST_PART    = 5'b00100,
		ST_FOLD    = 5'b01000,
		ST_EMIT    = 5'b10000
	} state_t;

endpackage

### rtl/haf_regs.sv
// ----------------------------------------------------------------------------
// haf_regs
// APB register file: fundamental, sample rate and partial count.
// ----------------------------------------------------------------------------
module haf_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [haf_pkg::ADDR_W-1:0]  paddr,
	input  logic [haf_pkg::DATA_W-1:0]  pwdata,
	output logic [haf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output haf_pkg::cfg_t               cfg
);

	logic [haf_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	haf_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[haf_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fund   <= haf_pkg::FUND_RST;
			cfg_q.srate  <= haf_pkg::SRATE_RST;
			cfg_q.nparts <= haf_pkg::NPART_RST;
		end else if (wr_en) begin
			unique case (idx)
				haf_pkg::REG_FUND:  cfg_q.fund   <= pwdata[haf_pkg::FUND_W-1:0];
				haf_pkg::REG_SRATE: cfg_q.srate  <= pwdata[haf_pkg::SRATE_W-1:0];
				haf_pkg::REG_NPART: cfg_q.nparts <= pwdata[haf_pkg::NPART_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			haf_pkg::REG_FUND:  prdata = haf_pkg::DATA_W'(cfg_q.fund);
			haf_pkg::REG_SRATE: prdata = haf_pkg::DATA_W'(cfg_q.srate);
			haf_pkg::REG_NPART: prdata = haf_pkg::DATA_W'(cfg_q.nparts);
			default:            prdata = '0;
		endcase
	end

endmodule

### rtl/haf_div.sv
// ----------------------------------------------------------------------------
// haf_div
// Bit-serial restoring divider: one quotient bit per cycle, shared between
// the Nyquist division and the per-partial folding modulo.
// ----------------------------------------------------------------------------
module haf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [haf_pkg::DIV_W-1:0]  dividend,
	input  logic [haf_pkg::DIV_W-1:0]  divisor,
	output haf_pkg::div_rsp_t          rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [haf_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [haf_pkg::DIV_W-1:0]        quo_q;
	logic [haf_pkg::DIV_W-1:0]        rem_q;
	logic [haf_pkg::DIV_W-1:0]        dvs_q;
	logic [haf_pkg::DIV_W:0]          trial;
	logic [haf_pkg::DIV_W:0]          diff;
	logic                             ge;
	logic [haf_pkg::DIV_W-1:0]        rem_nxt;

	// shift the next dividend bit into the partial remainder, try a subtract
	assign trial   = {rem_q, quo_q[haf_pkg::DIV_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign ge      = trial >= {1'b0, dvs_q};
	assign rem_nxt = ge ? diff[haf_pkg::DIV_W-1:0] : trial[haf_pkg::DIV_W-1:0];

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= haf_pkg::DIV_CNT_W'(haf_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[haf_pkg::DIV_W-2:0], ge};
		end
	end

endmodule

### rtl/harmonic_alias_folder_unit.sv
// ----------------------------------------------------------------------------
// harmonic_alias_folder_unit
// Folds the harmonics of a fundamental about the Nyquist of a decimated rate.
// ----------------------------------------------------------------------------
// Usage:
//   Set the fundamental, the sample rate and the partial count over the APB
//   port (byte addresses 0, 4, 8) while the block is idle. Each item on the
//   input channel carries a decimation rate; the block answers with one
//   result item per partial 1..n in ascending order, last set on the final
//   one. A zero rate gives one error item (status 1, last 1, rest zero).
//   The Nyquist division starts when the item is accepted; each partial
//   then passes a decision state, a shared division when it lies above a
//   nonzero Nyquist, and an emit state. The one bit-serial divider yields
//   one quotient bit per cycle and is shared by every division.
//   One item is worked on at a time; in_ready is high only while idle.
//   A finished result sits in the output register; if the receiver stalls,
//   the next partial is computed and then held until the register frees up.
//   Reset clears the state machine and out_valid and restores the register
//   reset values (fundamental 440 Hz, 48 kHz, 16 partials).
// ----------------------------------------------------------------------------
module harmonic_alias_folder_unit #(
	parameter int MAX_PARTIALS = haf_pkg::MAX_PARTIALS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [haf_pkg::ADDR_W-1:0]    paddr,
	input  logic [haf_pkg::DATA_W-1:0]    pwdata,
	output logic [haf_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [haf_pkg::RATE_W-1:0]    dec_factor,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [haf_pkg::NPART_W-1:0]   harm_idx,
	output logic [haf_pkg::FREQ_W-1:0]    harm_freq,
	output logic [haf_pkg::NY_W-1:0]      fold_freq,
	output logic                          folded,
	output logic [haf_pkg::NY_W-1:0]      ny_freq,
	output logic                          status,
	output logic                          last
);

	// partial count limit: the smaller of the parameter and the result limit
	localparam int PART_LIMIT_I = (MAX_PARTIALS < haf_pkg::RESULT_LIMIT) ?
		MAX_PARTIALS : haf_pkg::RESULT_LIMIT;
	localparam logic [haf_pkg::NPART_W-1:0] PART_LIMIT =
		haf_pkg::NPART_W'(PART_LIMIT_I);

	haf_pkg::cfg_t     cfg;
	haf_pkg::div_rsp_t div_rsp;
	haf_pkg::state_t   state_q;

	logic                          div_start;
	logic [haf_pkg::DIV_W-1:0]     div_dividend;
	logic [haf_pkg::DIV_W-1:0]     div_divisor;

	// per-item working registers
	logic [haf_pkg::NY_W-1:0]      ny_q;
	logic [haf_pkg::FREQ_W-1:0]    f_q;
	logic [haf_pkg::NPART_W-1:0]   k_q;
	logic [haf_pkg::NPART_W-1:0]   n_q;
	logic [haf_pkg::FUND_W-1:0]    fund_q;
	logic [haf_pkg::NY_W-1:0]      alias_q;
	logic                          fold_q;
	logic                          err_q;

	// output register
	logic                          out_valid_q;
	logic [haf_pkg::NPART_W-1:0]   pnum_q;
	logic [haf_pkg::FREQ_W-1:0]    ofreq_q;
	logic [haf_pkg::NY_W-1:0]      afreq_q;
	logic                          ofold_q;
	logic [haf_pkg::NY_W-1:0]      nyout_q;
	logic                          stat_q;
	logic                          last_q;

	logic                          in_acc;
	logic                          out_free;
	logic                          emit_fire;
	logic                          f_above;
	logic                          pend_last;
	logic [haf_pkg::NPART_W-1:0]   n_clamp;
	logic [haf_pkg::FREQ_W-1:0]    f_next;
	logic [haf_pkg::NY_W-1:0]      fold_val;

	haf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	haf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp)
	);

	assign in_ready  = (state_q == haf_pkg::ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign emit_fire = (state_q == haf_pkg::ST_EMIT) & out_free;

	// clamp the partial count to 1..limit
	assign n_clamp = (cfg.nparts == '0) ? haf_pkg::NPART_W'(1) :
		(cfg.nparts > PART_LIMIT) ? PART_LIMIT : cfg.nparts;

	assign f_above   = {1'b0, f_q} > ny_q;
	assign pend_last = err_q | (k_q == n_q);
	assign f_next    = f_q + haf_pkg::FREQ_W'(fund_q);

	// odd quotient folds back down from Nyquist, even keeps the remainder
	assign fold_val = div_rsp.quot[0] ? (ny_q - div_rsp.rem) : div_rsp.rem;

	// Nyquist division on accept, folding modulo per partial
	assign div_start = (in_acc & (dec_factor != '0)) |
		((state_q == haf_pkg::ST_PART) & f_above & (ny_q != '0));
	assign div_dividend = (state_q == haf_pkg::ST_IDLE) ?
		{cfg.srate, haf_pkg::SRATE_SH'(0)} : haf_pkg::DIV_W'(f_q);
	assign div_divisor = (state_q == haf_pkg::ST_IDLE) ?
		haf_pkg::DIV_W'(dec_factor) : ny_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= haf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load on emit, drop once the receiver takes the item
			out_valid_q <= emit_fire | (out_valid_q & ~out_ready);
			unique case (state_q)
				haf_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (dec_factor == '0) begin
							state_q <= haf_pkg::ST_EMIT;
						end else begin
							state_q <= haf_pkg::ST_NY_WAIT;
						end
					end
				end
				haf_pkg::ST_NY_WAIT: begin
					if (div_rsp.done) begin
						state_q <= haf_pkg::ST_PART;
					end
				end
				haf_pkg::ST_PART: begin
					if (f_above && ny_q != '0) begin
						state_q <= haf_pkg::ST_FOLD;
					end else begin
						state_q <= haf_pkg::ST_EMIT;
					end
				end
				haf_pkg::ST_FOLD: begin
					if (div_rsp.done) begin
						state_q <= haf_pkg::ST_EMIT;
					end
				end
				haf_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= pend_last ? haf_pkg::ST_IDLE : haf_pkg::ST_PART;
					end
				end
				default: state_q <= haf_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			haf_pkg::ST_IDLE: begin
				if (in_acc) begin
					fund_q  <= cfg.fund;
					f_q     <= (dec_factor == '0) ? '0 : haf_pkg::FREQ_W'(cfg.fund);
					k_q     <= (dec_factor == '0) ? '0 : haf_pkg::NPART_W'(1);
					n_q     <= n_clamp;
					err_q   <= (dec_factor == '0);
					alias_q <= '0;
					fold_q  <= 1'b0;
					if (dec_factor == '0) begin
						ny_q <= '0;
					end
				end
			end
			haf_pkg::ST_NY_WAIT: begin
				if (div_rsp.done) begin
					ny_q <= div_rsp.quot;
				end
			end
			haf_pkg::ST_PART: begin
				// at or below Nyquist passes; zero Nyquist folds to zero
				alias_q <= f_above ? '0 : haf_pkg::NY_W'(f_q);
				fold_q  <= f_above;
			end
			haf_pkg::ST_FOLD: begin
				if (div_rsp.done) begin
					alias_q <= fold_val;
				end
			end
			haf_pkg::ST_EMIT: begin
				if (out_free) begin
					pnum_q  <= k_q;
					ofreq_q <= f_q;
					afreq_q <= alias_q;
					ofold_q <= fold_q;
					nyout_q <= ny_q;
					stat_q  <= err_q;
					last_q  <= pend_last;
					k_q     <= k_q + 1'b1;
					f_q     <= f_next;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign harm_idx  = pnum_q;
	assign harm_freq = ofreq_q;
	assign fold_freq = afreq_q;
	assign folded    = ofold_q;
	assign ny_freq   = nyout_q;
	assign status    = stat_q;
	assign last      = last_q;

endmodule

### rtl/haf_chk.sv
// ----------------------------------------------------------------------------
// haf_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module haf_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [haf_pkg::NPART_W-1:0]   harm_idx,
	input  logic [haf_pkg::FREQ_W-1:0]    harm_freq,
	input  logic [haf_pkg::NY_W-1:0]      fold_freq,
	input  logic                          folded,
	input  logic [haf_pkg::NY_W-1:0]      ny_freq,
	input  logic                          status,
	input  logic                          last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fold_freq)
			&& $stable(harm_idx) && $stable(last))
		else $error("stalled result item changed");

	// an error item is single and zeroed
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && harm_idx == '0 && !folded
			&& ny_freq == '0)
		else $error("malformed error item");

	// an unfolded partial keeps its frequency
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && !folded |->
			fold_freq == haf_pkg::NY_W'(harm_freq)
			&& haf_pkg::NY_W'(harm_freq) <= ny_freq)
		else $error("unfolded partial altered");

	// a folded partial lands at or below Nyquist
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && folded |-> fold_freq <= ny_freq
			&& harm_idx != '0)
		else $error("folded partial above Nyquist");

endmodule

bind harmonic_alias_folder_unit haf_chk u_chk (.*);
